/* rtl/twd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie word dictionary package
// Shared sizes, codes and types of the trie dictionary front and back ends.
// ----------------------------------------------------------------------------
package twd_pkg;

   localparam int MAX_NODES     = 1024;
   localparam int ALPHABET_SIZE = 26;
   localparam int NODE_W        = $clog2(MAX_NODES);
   localparam int FREE_W        = NODE_W + 1;
   localparam int IDX_W         = $clog2(ALPHABET_SIZE);
   localparam int SLOT_COUNT    = MAX_NODES * ALPHABET_SIZE;
   localparam int SLOT_W        = $clog2(SLOT_COUNT);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_DELETE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_BADCHAR = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [IDX_W-1:0] idx;
      logic             letter_ok;
      logic             last;
   } item_type;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_LINK  = 4'b0100,
      S_MARK  = 4'b1000
   } state_type;

endpackage

/* rtl/twd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie dictionary front end
// Accepts requests, folds and checks the letter, decodes the command and
// holds classified requests in a short queue for the back end.
// ----------------------------------------------------------------------------
module twd_front
   import twd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // command[1:0], letter[9:2], zero fill
   input  logic        req_tlast,
   input  logic        clearing,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic [7:0]            letter;
   logic [7:0]            folded;
   item_type              classified;
   logic                  push;

   always_comb begin
      letter = req_tdata[9:2];
      if (letter >= CHAR_UPPER_A && letter <= CHAR_UPPER_Z) begin
         folded = letter + CASE_OFFSET;
      end else begin
         folded = letter;
      end
      classified.letter_ok = (folded >= CHAR_LOWER_A) && (folded <= CHAR_LOWER_Z);
      classified.idx       = IDX_W'(folded - CHAR_LOWER_A);
      classified.last      = req_tlast;
      unique case (req_tdata[1:0])
         CMD_INSERT: classified.cmd = CMD_INSERT;
         CMD_DELETE: classified.cmd = CMD_DELETE;
         default:    classified.cmd = CMD_SEARCH;
      endcase
   end

   assign req_tready = !clearing && (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_item     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

/* rtl/twd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie dictionary back end
// Walks the node table one character at a time, allocates nodes on insert,
// updates word-end marks and drives the registered result.
// ----------------------------------------------------------------------------
module twd_back
   import twd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   output logic       clearing,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata     // found[0], status[2:1], zero fill
);

   logic [NODE_W-1:0] link_mem [SLOT_COUNT];
   logic              mark_mem [MAX_NODES];

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] walk_node_ff, walk_node_in;
   status_type        word_status_ff, word_status_in;
   logic              path_missing_ff, path_missing_in;
   logic [FREE_W-1:0] free_count_ff, free_count_in;
   logic [SLOT_W-1:0] clear_cnt_ff, clear_cnt_in;
   item_type          item_ff, item_in;
   logic [SLOT_W-1:0] slot_addr_ff, slot_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [NODE_W-1:0] link_rd_ff;
   logic              mark_rd_ff;

   logic              link_we, link_re;
   logic [SLOT_W-1:0] link_wa, link_ra;
   logic [NODE_W-1:0] link_wd;
   logic              mark_we, mark_re;
   logic [NODE_W-1:0] mark_wa, mark_ra;
   logic              mark_wd;
   logic [SLOT_W-1:0] slot_calc;
   logic              out_free;
   logic              active;
   logic              do_walk;

   assign slot_calc = SLOT_W'(walk_node_ff) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(q_item.idx);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign active    = (word_status_ff == ST_OK);
   assign do_walk   = active && q_item.letter_ok
                      && !(path_missing_ff && q_item.cmd != CMD_INSERT);

   always_comb begin
      state_in        = state_ff;
      walk_node_in    = walk_node_ff;
      word_status_in  = word_status_ff;
      path_missing_in = path_missing_ff;
      free_count_in   = free_count_ff;
      clear_cnt_in    = clear_cnt_ff;
      item_in         = item_ff;
      slot_addr_in    = slot_addr_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_found_in    = rsp_found_ff;
      rsp_status_in   = rsp_status_ff;
      q_pop           = 1'b0;
      link_we         = 1'b0;
      link_wa         = slot_addr_ff;
      link_wd         = free_count_ff[NODE_W-1:0];
      link_re         = 1'b0;
      link_ra         = slot_calc;
      mark_we         = 1'b0;
      mark_wa         = walk_node_ff;
      mark_wd         = 1'b0;
      mark_re         = 1'b0;
      mark_ra         = walk_node_ff;

      unique case (state_ff)
         S_CLEAR: begin
            link_we = 1'b1;
            link_wa = clear_cnt_ff;
            link_wd = '0;
            if (clear_cnt_ff < SLOT_W'(MAX_NODES)) begin
               mark_we = 1'b1;
               mark_wa = clear_cnt_ff[NODE_W-1:0];
               mark_wd = (clear_cnt_ff == '0);
            end
            if (clear_cnt_ff == SLOT_W'(SLOT_COUNT - 1)) begin
               state_in = S_IDLE;
            end else begin
               clear_cnt_in = clear_cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop        = 1'b1;
               item_in      = q_item;
               slot_addr_in = slot_calc;
               if (active && !q_item.letter_ok) begin
                  word_status_in = ST_BADCHAR;
               end
               if (do_walk) begin
                  link_re  = 1'b1;
                  state_in = S_LINK;
               end else if (q_item.last) begin
                  mark_re  = 1'b1;
                  state_in = S_MARK;
               end
            end
         end
         S_LINK: begin
            if (link_rd_ff != '0) begin
               walk_node_in = link_rd_ff;
            end else begin
               path_missing_in = 1'b1;
               if (item_ff.cmd == CMD_INSERT) begin
                  if (free_count_ff >= FREE_W'(MAX_NODES)) begin
                     word_status_in = ST_FULL;
                  end else begin
                     link_we       = 1'b1;
                     walk_node_in  = free_count_ff[NODE_W-1:0];
                     free_count_in = free_count_ff + 1'b1;
                  end
               end
            end
            if (item_ff.last) begin
               mark_re  = 1'b1;
               mark_ra  = walk_node_in;
               state_in = S_MARK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MARK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = word_status_ff;
               rsp_found_in  = 1'b0;
               if (word_status_ff == ST_OK) begin
                  case (item_ff.cmd)
                     CMD_INSERT: begin
                        mark_we      = 1'b1;
                        mark_wd      = 1'b1;
                        rsp_found_in = !path_missing_ff;
                     end
                     CMD_DELETE: begin
                        mark_we      = !path_missing_ff;
                        mark_wd      = 1'b0;
                        rsp_found_in = !path_missing_ff;
                     end
                     default: begin
                        rsp_found_in = !path_missing_ff && mark_rd_ff;
                     end
                  endcase
               end
               walk_node_in    = '0;
               word_status_in  = ST_OK;
               path_missing_in = 1'b0;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         walk_node_ff    <= '0;
         word_status_ff  <= ST_OK;
         path_missing_ff <= 1'b0;
         free_count_ff   <= FREE_W'(1);
         clear_cnt_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         walk_node_ff    <= walk_node_in;
         word_status_ff  <= word_status_in;
         path_missing_ff <= path_missing_in;
         free_count_ff   <= free_count_in;
         clear_cnt_ff    <= clear_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      slot_addr_ff  <= slot_addr_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      if (mark_re) begin
         mark_rd_ff <= mark_mem[mark_ra];
      end
   end

   assign clearing   = (state_ff == S_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_status_ff, rsp_found_ff};

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= FREE_W'(MAX_NODES))
      else $error("free node count ran past the table size");

   a_walk_allocated: assert property (@(posedge clock) disable iff (reset)
      FREE_W'(walk_node_ff) < free_count_ff)
      else $error("walk points at a node that was never allocated");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE) && q_valid)
      else $error("queue popped outside the idle state or while empty");

   a_link_after_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LINK) |-> $past(state_ff == S_IDLE))
      else $error("link stage entered without a request from idle");

   a_no_result_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("result presented during the clearing pass");

endmodule

/* rtl/trie_word_dictionary.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie word dictionary
// A 26-letter trie held in a node table, fed one character per request.
// ----------------------------------------------------------------------------
// Each request on the req_ channel carries one character, its command and a
// tlast mark on the final character of the word. Upper-case letters are
// folded to lower case. One result leaves on the rsp_ channel for each word,
// after its final character, with found and status.
// After reset the block sweeps the child-link table, one entry a cycle, and
// req_tready stays low during that pass.
// A two-entry queue sits between the front end and the walk engine, so
// requests are taken while the engine works or a result waits.
// A character that needs no table walk is handled in the idle state; one that
// does also passes through the link state for the registered child-link read.
// The final character then passes through the mark state for the registered
// word-end mark read. A word's final request thus goes from the queue through
// idle, link if it needs a walk, mark and then the result register.
// The result register holds its value while rsp_tready is low; the engine
// then stops at the end of the next word and the queue fills.
// ----------------------------------------------------------------------------
module trie_word_dictionary
   import twd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // command[1:0], letter[9:2], zero fill
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // found[0], status[2:1], zero fill
);

   logic     q_valid;
   item_type q_item;
   logic     q_pop;
   logic     clearing;

   twd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .clearing   (clearing),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   twd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie word dictionary testbench
// Drives words one character per request into the dictionary and checks every
// word result against a trie model in the bench or a typed result of the table.
// A short table of directed requests comes first, then random words with long
// receiver stalls and a stretch of back-to-back requests.
// ----------------------------------------------------------------------------
module tb;
   import twd_pkg::*;

   localparam logic [1:0] CMD_ALIAS   = 2'd3;
   localparam int         IDLE_LIMIT  = 100000;
   localparam int         HOLD_CYCLES = 300;
   localparam int         DRAIN_TAIL  = 20;

   typedef struct packed {
      logic       found;
      status_type status;
   } word_result_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] ch;
      logic       last;
      logic       typed;
      logic       found;
      status_type status;
   } dir_row_type;

   typedef enum {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   localparam dir_row_type DIR_ROWS [26] = '{
      '{CMD_SEARCH, "a",   1'b1, 1'b1, 1'b0, ST_OK},
      '{CMD_INSERT, "a",   1'b0, 1'b0, 1'b0, ST_OK},
      '{CMD_INSERT, "B",   1'b0, 1'b0, 1'b0, ST_OK},
      '{CMD_INSERT, "c",   1'b1, 1'b0, 1'b0, ST_OK},
      '{CMD_SEARCH, "A",   1'b0, 1'b0, 1'b0, ST_OK},
      '{CMD_SEARCH, "b",   1'b0, 1'b0, 1'b0, ST_OK},
      '{CMD_SEARCH, "C",   1'b1, 1'b0, 1'b0, ST_OK},
      '{CMD_DELETE, "a",   1'b0, 1'b0, 1'b0, ST_OK},
      '{CMD_DELETE, "b",   1'b0, 1'b0, 1'b0, ST_OK},
      '{CMD_DELETE, "c",   1'b1, 1'b0, 1'b0, ST_OK},
      '{CMD_ALIAS,  "a",   1'b0, 1'b0, 1'b0, ST_OK},
      '{CMD_ALIAS,  "b",   1'b0, 1'b0, 1'b0, ST_OK},
      '{CMD_ALIAS,  "c",   1'b1, 1'b0, 1'b0, ST_OK},
      '{CMD_INSERT, "z",   1'b0, 1'b0, 1'b0, ST_OK},
      '{CMD_INSERT, "Z",   1'b1, 1'b1, 1'b0, ST_OK},
      '{CMD_INSERT, 8'h00, 1'b1, 1'b1, 1'b0, ST_BADCHAR},
      '{CMD_SEARCH, 8'hFF, 1'b1, 1'b1, 1'b0, ST_BADCHAR},
      '{CMD_INSERT, "q",   1'b0, 1'b0, 1'b0, ST_OK},
      '{CMD_INSERT, 8'h40, 1'b0, 1'b0, 1'b0, ST_OK},
      '{CMD_INSERT, "r",   1'b1, 1'b1, 1'b0, ST_BADCHAR},
      '{CMD_DELETE, 8'h5B, 1'b1, 1'b1, 1'b0, ST_BADCHAR},
      '{CMD_SEARCH, 8'h60, 1'b1, 1'b1, 1'b0, ST_BADCHAR},
      '{CMD_INSERT, 8'h7B, 1'b1, 1'b1, 1'b0, ST_BADCHAR},
      '{CMD_INSERT, "m",   1'b0, 1'b0, 1'b0, ST_OK},
      '{CMD_SEARCH, "n",   1'b1, 1'b0, 1'b0, ST_OK},
      '{CMD_DELETE, "x",   1'b1, 1'b0, 1'b0, ST_OK}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;

   logic [NODE_W-1:0] child_of [SLOT_COUNT];
   logic              word_end [MAX_NODES];
   logic [FREE_W-1:0] next_free;
   logic [NODE_W-1:0] walk_at;
   status_type        word_fail;
   logic              strayed;

   word_result_type expected_words [$];
   int              mismatches;
   int              idle_cycles;
   int              chars_sent;
   int              burst_left;
   bit              gaps_on;
   bit              hold_rsp;

   trie_word_dictionary u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic trie_reset();
      foreach (child_of[s]) child_of[s] = '0;
      foreach (word_end[n]) word_end[n] = 1'b0;
      word_end[0] = 1'b1;
      next_free   = FREE_W'(1);
      walk_at     = '0;
      word_fail   = ST_OK;
      strayed     = 1'b0;
   endtask

   task automatic trie_apply_char(input logic [1:0] cmd_raw, input logic [7:0] raw,
                                  input logic last, output bit has_word,
                                  output word_result_type res);
      cmd_type    cmd;
      logic [7:0] ch;
      int         slot;
      cmd      = (cmd_raw == CMD_ALIAS) ? CMD_SEARCH : cmd_type'(cmd_raw);
      ch       = raw;
      has_word = 1'b0;
      res      = '0;
      if (raw >= CHAR_UPPER_A && raw <= CHAR_UPPER_Z) ch = raw + CASE_OFFSET;
      if (word_fail == ST_OK) begin
         if (ch < CHAR_LOWER_A || ch > CHAR_LOWER_Z) begin
            word_fail = ST_BADCHAR;
         end else if (!(strayed && cmd != CMD_INSERT)) begin
            slot = int'(walk_at) * ALPHABET_SIZE + int'(ch - CHAR_LOWER_A);
            if (child_of[slot] != '0) begin
               walk_at = child_of[slot];
            end else begin
               strayed = 1'b1;
               if (cmd == CMD_INSERT) begin
                  if (next_free >= MAX_NODES) begin
                     word_fail = ST_FULL;
                  end else begin
                     word_end[next_free[NODE_W-1:0]] = 1'b0;
                     child_of[slot] = next_free[NODE_W-1:0];
                     walk_at        = next_free[NODE_W-1:0];
                     next_free      = next_free + 1'b1;
                  end
               end
            end
         end
      end
      if (last) begin
         has_word   = 1'b1;
         res.status = word_fail;
         if (word_fail == ST_OK) begin
            case (cmd)
               CMD_INSERT: begin
                  word_end[walk_at] = 1'b1;
                  res.found = !strayed;
               end
               CMD_DELETE: begin
                  if (!strayed) word_end[walk_at] = 1'b0;
                  res.found = !strayed;
               end
               default: begin
                  res.found = !strayed && word_end[walk_at];
               end
            endcase
         end
         walk_at   = '0;
         word_fail = ST_OK;
         strayed   = 1'b0;
      end
   endtask

   task automatic send_char(input logic [1:0] cmd, input logic [7:0] ch, input logic last,
                            input logic typed, input word_result_type typed_res);
      int              gap;
      bit              has_word;
      word_result_type res;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = gaps_on ? $urandom_range(0, 5) : 0;
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, ch, cmd};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      trie_apply_char(cmd, ch, last, has_word, res);
      if (has_word) expected_words.push_back(typed ? typed_res : res);
      chars_sent++;
   endtask

   task automatic wait_all_words();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic random_word();
      logic [1:0] cmd;
      logic [1:0] c;
      logic [7:0] ch;
      int         len;
      int         pick;
      int         span;
      pick = $urandom_range(0, 99);
      if (pick < 40) cmd = CMD_INSERT;
      else if (pick < 70) cmd = CMD_SEARCH;
      else if (pick < 92) cmd = CMD_DELETE;
      else cmd = CMD_ALIAS;
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
      span = ($urandom_range(0, 3) == 0) ? ALPHABET_SIZE - 1 : 3;
      for (int i = 0; i < len; i++) begin
         ch = CHAR_LOWER_A + 8'($urandom_range(0, span));
         if ($urandom_range(0, 1) == 1) ch = ch - CASE_OFFSET;
         pick = $urandom_range(0, 99);
         if (pick < 4) ch = 8'($urandom_range(0, 255));
         c = cmd;
         if (pick >= 95) c = 2'($urandom_range(0, 3));
         send_char(c, ch, i == len - 1, 1'b0, '0);
      end
   endtask

   initial begin
      rx_mode_type mode;
      int          left;
      mode = RX_FREE;
      left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         if (left == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
            left = $urandom_range(20, 120);
         end
         left--;
         case (mode)
            RX_FREE:   rsp_tready <= 1'b1;
            RX_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= (left % 3 != 0);
         endcase
      end
   end

   always @(posedge clock) begin : check_words
      word_result_type want;
      word_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.found  = rsp_tdata[0];
         got.status = status_type'(rsp_tdata[2:1]);
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("tb: result with nothing expected, data %h", rsp_tdata);
            end
         end else begin
            want = expected_words.pop_front();
            if (got.found !== want.found || got.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display({"tb: word result mismatch, expected found %b status %0d, ",
                            "got found %b status %0d"},
                           want.found, want.status, got.found, got.status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      mismatches  = 0;
      idle_cycles = 0;
      chars_sent  = 0;
      burst_left  = 0;
      gaps_on     = 1'b1;
      hold_rsp    = 1'b0;
      trie_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_ROWS[r]) begin
         send_char(DIR_ROWS[r].cmd, DIR_ROWS[r].ch, DIR_ROWS[r].last, DIR_ROWS[r].typed,
                   '{DIR_ROWS[r].found, DIR_ROWS[r].status});
      end
      wait_all_words();

      while (chars_sent < 120) random_word();
      hold_rsp = 1'b1;
      while (chars_sent < 260) random_word();
      wait_all_words();

      // Back-to-back requests with no sender gaps.
      gaps_on = 1'b0;
      while (chars_sent < 330) random_word();
      gaps_on  = 1'b1;
      hold_rsp = 1'b1;
      while (chars_sent < 400) random_word();

      wait_all_words();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
